FILE: hdl/itrd_pkg.sv
// Shared types, constants and helper functions for the radix digit converter.
package itrd_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned BASE_W  = 6;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned CNT_W   = 5;

    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] DIGIT_MAX  = 6'd9;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_TEN   = 7'd10;

    localparam logic [CNT_W-1:0] STEP_LAST = 5'd31;

    localparam logic ADDR_RADIX = 1'b0;

    typedef struct packed {
        logic load;
        logic step;
        logic push_digit;
        logic push_sign;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic step_done;
        logic quo_zero;
        logic neg;
        logic out_free;
    } t_dp_sts;

    function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] r);
        logic [BASE_W-1:0] b;
        b = r;
        if (r < BASE_MIN) begin
            b = BASE_MIN;
        end else if (r > BASE_MAX) begin
            b = BASE_MAX;
        end
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_MAX) begin
            c = CHAR_W'(d) + CHAR_A - CHAR_TEN;
        end else begin
            c = CHAR_W'(d) + CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

FILE: hdl/integer_to_radix_digits_core.sv
// Top level: signed integer to ASCII radix digits, with APB radix register.
// Per digit: 32 divider steps of one quotient bit each, then a push once the output is free.
// A new value is accepted only in idle, after the last character of the previous value
//   (digits and any minus sign) has been pushed; the single bit-serial divider sets the pace.
// The output register lets the next digit be worked while a character waits to be taken.
// Reset: synchronous, active low; clears control state and sets radix to ten.
module integer_to_radix_digits_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] character, [7] zero
    output logic        m_axis_tlast
);
    import itrd_pkg::*;

    logic [BASE_W-1:0] r_radix;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [CHAR_W-1:0] w_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= BASE_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_RADIX)) begin
            r_radix <= pwdata[BASE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_RADIX) ? {{(32-BASE_W){1'b0}}, r_radix} : '0;

    itrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    itrd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (s_axis_tdata),
        .i_radix     (r_radix),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (w_char),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_char};

endmodule

FILE: hdl/itrd_dp.sv
// Datapath: magnitude register, bit-serial restoring divider and output register.
module itrd_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [itrd_pkg::VALUE_W-1:0]      i_value,
    input  logic [itrd_pkg::BASE_W-1:0]       i_radix,
    input  itrd_pkg::t_dp_cmd                 i_cmd,
    output itrd_pkg::t_dp_sts                 o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [itrd_pkg::CHAR_W-1:0]       o_out_char,
    output logic                              o_out_last
);
    import itrd_pkg::*;

    logic [VALUE_W-1:0] r_mag, n_mag;
    logic [BASE_W-1:0]  r_rem, n_rem;
    logic [BASE_W-1:0]  r_base;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_neg;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;

    logic [BASE_W:0]    w_trial;
    logic               w_ge;
    logic               w_out_free;

    assign w_trial    = {r_rem, r_mag[VALUE_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_base};
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_mag = r_mag;
        n_rem = r_rem;
        n_cnt = r_cnt;
        priority if (i_cmd.load) begin
            n_mag = i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
            n_rem = '0;
            n_cnt = '0;
        end else if (i_cmd.step) begin
            n_mag = {r_mag[VALUE_W-2:0], w_ge};
            n_rem = w_ge ? BASE_W'(w_trial - {1'b0, r_base}) : w_trial[BASE_W-1:0];
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_cmd.push_digit) begin
            n_rem = '0;
            n_cnt = '0;
        end else begin
            n_rem = r_rem;
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_cmd.load) begin
            r_neg  <= i_value[VALUE_W-1];
            r_base <= eff_base(i_radix);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            priority if (i_cmd.push_digit || i_cmd.push_sign) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.push_digit) begin
            r_out_char <= digit_char(r_rem);
            r_out_last <= i_cmd.last;
        end else if (i_cmd.push_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= i_cmd.last;
        end else begin
            r_out_char <= r_out_char;
            r_out_last <= r_out_last;
        end
    end

    assign o_sts.step_done = (r_cnt == STEP_LAST);
    assign o_sts.quo_zero  = (r_mag == '0);
    assign o_sts.neg       = r_neg;
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

FILE: hdl/itrd_ctrl.sv
// Controller: sequences division steps, digit pushes and the sign character.
module itrd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  itrd_pkg::t_dp_sts i_sts,
    output itrd_pkg::t_dp_cmd o_cmd
);
    import itrd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH,
        ST_SIGN
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (i_sts.step_done) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (i_sts.out_free) begin
                        priority if (!i_sts.quo_zero) begin
                            r_state <= ST_DIV;
                        end else if (i_sts.neg) begin
                            r_state <= ST_SIGN;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_SIGN: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_PUSH: begin
                o_cmd.push_digit = i_sts.out_free;
                o_cmd.last       = i_sts.quo_zero && !i_sts.neg;
            end
            ST_SIGN: begin
                o_cmd.push_sign = i_sts.out_free;
                o_cmd.last      = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the integer to radix digit converter core.
module testbench;

    localparam logic [2:0] RADIX_ADDR = 3'd0;
    localparam logic [2:0] SPARE_ADDR = 3'd4;
    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_A       = 7'h41;
    localparam logic [6:0] CH_MINUS   = 7'h2D;
    localparam int         HOLD_CYCLES = 2500;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  addr;
        logic [31:0] word;
        string       want;
    } t_stim_row;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_char_exp;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [6:0] character, [7] zero
    logic        m_axis_tlast;

    t_char_exp   digits_due[$];
    t_char_exp   head_due;
    t_stim_row   plan[$];
    logic [5:0]  radix_reg;
    logic [5:0]  phase_radix[10] = '{6'd2, 6'd36, 6'd10, 6'd16, 6'd8,
                                     6'd0, 6'd63, 6'd1, 6'd37, 6'd5};
    int          mismatches;
    int          hold_left;
    bit          hold_req;
    bit          calm;

    integer_to_radix_digits_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch: %s got %0h want %0h", what, got, want);
        mismatches++;
    endtask

    function automatic void predict_digits(input logic [31:0] v);
        logic [31:0] mag;
        logic [31:0] base;
        logic [31:0] rem;
        int          n;
        base = (radix_reg < 6'd2) ? 32'd2 : (radix_reg > 6'd36) ? 32'd36 : 32'(radix_reg);
        mag  = v[31] ? 32'd0 - v : v;
        n    = 0;
        do begin
            rem = mag % base;
            mag = mag / base;
            digits_due.push_back({(rem > 32'd9) ? rem[6:0] - 7'd10 + CH_A
                                                : rem[6:0] + CH_ZERO, 1'b0});
            n++;
        end while (mag != 32'd0 && n < 32);
        if (v[31]) begin
            digits_due.push_back({CH_MINUS, 1'b0});
        end
        digits_due[$].last = 1'b1;
    endfunction

    task automatic send_value(input logic [31:0] v, input string want);
        int  gap;
        byte c;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        if (want.len() == 0) begin
            predict_digits(v);
        end else begin
            for (int i = 0; i < want.len(); i++) begin
                c = want[i];
                digits_due.push_back({c[6:0], i == want.len() - 1});
            end
        end
        gap = (!calm && $urandom_range(99) < 25) ? int'($urandom_range(1, 12)) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        wait (digits_due.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic set_register(input logic [2:0] addr, input logic [31:0] word);
        logic [31:0] got;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
        if (addr == RADIX_ADDR) begin
            radix_reg = word[5:0];
        end
        pwrite  <= 1'b0;
        paddr   <= RADIX_ADDR;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        got = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {26'd0, radix_reg}) begin
            flag_mismatch("radix readback", got, {26'd0, radix_reg});
        end
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 25);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digits_due.size() == 0) begin
                flag_mismatch("transaction with nothing due", m_axis_tdata, 32'd0);
            end else begin
                head_due = digits_due.pop_front();
                if (m_axis_tdata !== {1'b0, head_due.ch}) begin
                    flag_mismatch("character", m_axis_tdata, head_due.ch);
                end
                if (m_axis_tlast !== head_due.last) begin
                    flag_mismatch("last", m_axis_tlast, head_due.last);
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [31:0] word;
        logic [31:0] v;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = RADIX_ADDR;
        pwdata        = 32'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'd0;
        radix_reg     = 6'd10;
        mismatches    = 0;
        hold_req      = 1'b0;
        calm          = 1'b0;

        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'd0,          "0"});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'd7,          "7"});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'hFFFFFFFF,   "1-"});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'h7FFFFFFF,   "7463847412"});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'h80000000,   "8463847412-"});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'd123,        ""});
        plan.push_back('{ROW_CFG,  RADIX_ADDR, 32'd2,          ""});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'h80000000,
                         {"0000000000", "0000000000", "0000000000", "0", "1-"}});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'hFFFFFFFF,   "1-"});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'h7FFFFFFF,   ""});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'd5,          "101"});
        plan.push_back('{ROW_CFG,  RADIX_ADDR, 32'd36,         ""});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'd35,         "Z"});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'd36,         "01"});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, -32'sd35,       "Z-"});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'h80000000,   ""});
        plan.push_back('{ROW_CFG,  RADIX_ADDR, 32'd16,         ""});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'hDEADBEEF,   ""});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'd255,        "FF"});
        plan.push_back('{ROW_CFG,  RADIX_ADDR, 32'hFFFFFFC1,   ""});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'd6,          "011"});
        plan.push_back('{ROW_CFG,  RADIX_ADDR, 32'd0,          ""});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'd2,          "01"});
        plan.push_back('{ROW_CFG,  RADIX_ADDR, 32'd37,         ""});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'd71,         "Z1"});
        plan.push_back('{ROW_CFG,  RADIX_ADDR, 32'd63,         ""});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, -32'sd1296,     "001-"});
        plan.push_back('{ROW_CFG,  SPARE_ADDR, 32'd3,          ""});
        plan.push_back('{ROW_ITEM, RADIX_ADDR, 32'd36,         "01"});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                drain_results();
                set_register(plan[r].addr, plan[r].word);
            end else begin
                send_value(plan[r].word, plan[r].want);
            end
        end

        for (int p = 0; p < 10; p++) begin
            drain_results();
            word = $urandom_range(1) ? $urandom : 32'd0;
            word[5:0] = (p == 9) ? 6'($urandom_range(63)) : phase_radix[p];
            set_register(RADIX_ADDR, word);
            calm = (p == 3);
            for (int k = 0; k < 25; k++) begin
                if (p == 6 && k == 4) begin
                    hold_req = 1'b1;
                end
                case ($urandom_range(4))
                    0: v = $urandom;
                    1: v = $urandom_range(0, 50);
                    2: v = 32'd0 - $urandom_range(1, 50);
                    3: begin
                        case ($urandom_range(3))
                            0:       v = 32'd0;
                            1:       v = 32'hFFFFFFFF;
                            2:       v = 32'h80000000;
                            default: v = 32'h7FFFFFFF;
                        endcase
                    end
                    default: begin
                        v = $urandom >> $urandom_range(31);
                        if ($urandom_range(1)) begin
                            v = 32'd0 - v;
                        end
                    end
                endcase
                send_value(v, "");
            end
        end

        drain_results();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
